[hdl/plms_pkg.sv]
package plms_pkg;

    localparam int MAX_ENTRIES_DEF    = 128;
    localparam int MAX_PHRASE_LEN_DEF = 32;
    localparam int LEN_W              = 6;

    localparam logic [1:0] CMD_WR_BYTE = 2'd0;
    localparam logic [1:0] CMD_SET_LEN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    localparam logic [2:0] CL_NONE    = 3'd0;
    localparam logic [2:0] CL_WORD    = 3'd1;
    localparam logic [2:0] CL_SPACE   = 3'd2;
    localparam logic [2:0] CL_NEWLINE = 3'd3;
    localparam logic [2:0] CL_UTF8    = 3'd4;
    localparam logic [2:0] CL_PUNCT   = 3'd5;
    localparam logic [2:0] CL_RAW     = 3'd6;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_RAW   = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] entry_index;
        logic [4:0] char_offset;
        logic [5:0] phrase_length;
        logic [7:0] byte_value;
        logic       text_last;
    } t_in_item;

    typedef struct packed {
        logic        seg_kind;
        logic [31:0] seg_start;
        logic [31:0] seg_length;
        logic        burst_end;
        logic        text_end;
    } t_seg_item;

    // Control of the lookahead cell row.
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] data;
    } t_win_ctl;

    function automatic logic [2:0] byte_class(input logic [7:0] b);
        logic [2:0] c;
        if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
            (b >= 8'h30 && b <= 8'h39) || b == 8'h5f || b == 8'h27) begin
            c = CL_WORD;
        end else if (b == 8'h0a || b == 8'h0d) begin
            c = CL_NEWLINE;
        end else if (b == 8'h20 || b == 8'h09 || b == 8'h0b || b == 8'h0c) begin
            c = CL_SPACE;
        end else if (b >= 8'h80) begin
            c = CL_UTF8;
        end else if (b >= 8'h20 && b <= 8'h7e) begin
            c = CL_PUNCT;
        end else begin
            c = CL_RAW;
        end
        return c;
    endfunction

endpackage

[hdl/plms_cell.sv]
// One lookahead byte: loads a new text byte, takes its right neighbor's byte on
// a shift, and compares itself with the phrase byte at the same position.
module plms_cell (
    input  logic       i_clk,
    input  logic       i_load,
    input  logic       i_shift,
    input  logic [7:0] i_load_byte,
    input  logic [7:0] i_next_byte,
    input  logic [7:0] i_ref_byte,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_load_byte;
        end else if (i_shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq   = (r_byte == i_ref_byte);

endmodule

[hdl/plms_window.sv]
// Row of lookahead cells; cell 0 is the head of the window.
module plms_window #(
    parameter int MAX_PHRASE_LEN = plms_pkg::MAX_PHRASE_LEN_DEF,
    parameter int FW             = $clog2(MAX_PHRASE_LEN + 1)
) (
    input  logic                          i_clk,
    input  plms_pkg::t_win_ctl            i_ctl,
    input  logic [FW-1:0]                 i_fill,
    input  logic [8*MAX_PHRASE_LEN-1:0]   i_row,
    input  logic [plms_pkg::LEN_W-1:0]    i_len,
    output logic [7:0]                    o_head,
    output logic                          o_match
);

    logic [7:0]                cell_byte [MAX_PHRASE_LEN];
    logic [MAX_PHRASE_LEN-1:0] eq;
    logic [MAX_PHRASE_LEN-1:0] care;

    for (genvar i = 0; i < MAX_PHRASE_LEN; i++) begin : g_cell
        logic [7:0] next_byte;
        if (i == MAX_PHRASE_LEN - 1) begin : g_tail
            assign next_byte = 8'h00;
        end else begin : g_mid
            assign next_byte = cell_byte[i+1];
        end

        plms_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctl.load && (i_fill == FW'(i))),
            .i_shift     (i_ctl.shift),
            .i_load_byte (i_ctl.data),
            .i_next_byte (next_byte),
            .i_ref_byte  (i_row[8*i +: 8]),
            .o_byte      (cell_byte[i]),
            .o_eq        (eq[i])
        );

        assign care[i] = (i < int'(i_len));
    end

    assign o_head  = cell_byte[0];
    assign o_match = &(eq | ~care);

endmodule

[hdl/plms_dict.sv]
// Phrase dictionary: one row of bytes per entry plus a length per entry.
module plms_dict #(
    parameter int MAX_ENTRIES    = plms_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PHRASE_LEN = plms_pkg::MAX_PHRASE_LEN_DEF,
    parameter int AW             = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int OW             = $clog2(MAX_PHRASE_LEN)
) (
    input  logic                        i_clk,
    input  logic                        i_st_we,
    input  logic [AW-1:0]               i_st_addr,
    input  logic [OW-1:0]               i_st_off,
    input  logic [7:0]                  i_st_byte,
    input  logic                        i_ln_we,
    input  logic [AW-1:0]               i_ln_addr,
    input  logic [plms_pkg::LEN_W-1:0]  i_ln_val,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [8*MAX_PHRASE_LEN-1:0] o_row,
    output logic [plms_pkg::LEN_W-1:0]  o_len
);

    logic [8*MAX_PHRASE_LEN-1:0] r_store [MAX_ENTRIES];
    logic [plms_pkg::LEN_W-1:0]  r_lens  [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            r_store[i_st_addr][8*i_st_off +: 8] <= i_st_byte;
        end
        o_row <= r_store[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ln_we) begin
            r_lens[i_ln_addr] <= i_ln_val;
        end
        o_len <= r_lens[i_rd_addr];
    end

endmodule

[hdl/phrase_longest_match_segmenter.sv]
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (plms_pkg::t_in_item)
// output    out        o_out_valid / i_out_ready  o_out_data (plms_pkg::t_seg_item)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Dictionary commands are taken while idle and the block stays ready for the next item.
// A text byte that only fills the window goes back to idle without a decision. A text
// byte that triggers a decision runs a scan over the entries in use: the scan reads
// one dictionary row per cycle from the phrase memory. A byte covered by an earlier
// match is shifted out without a scan.
// The final byte drains the whole window, scanning or skipping each byte in turn,
// then closes the run and hands over the last beat.
// After reset a clearing pass over every entry zeroes the length memory;
// no item is taken during it. A stalled output only holds the sequencer when a
// segment has to move into an output register that is still full.
module phrase_longest_match_segmenter #(
    parameter int MAX_ENTRIES    = plms_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PHRASE_LEN = plms_pkg::MAX_PHRASE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plms_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plms_pkg::t_seg_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_PHRASE_LEN);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int FW = $clog2(MAX_PHRASE_LEN + 1);
    localparam int LW = plms_pkg::LEN_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_NEXT, S_DEC, S_SCAN, S_DECIDE,
        S_PUSH0, S_PUSH1, S_SHIFT, S_CLOSE, S_FIN
    } t_state;

    t_state r_state;

    // Configuration register.
    logic [7:0] r_eiu;

    // Text state.
    logic [FW-1:0] r_fill;
    logic [31:0]   r_pos;
    logic [31:0]   r_rstart;
    logic [2:0]    r_rcls;
    logic [LW-1:0] r_skip;
    logic          r_last;
    logic          r_closing;

    // Dictionary scan.
    logic [EW-1:0] r_e;
    logic          r_cvld;
    logic [LW-1:0] r_best;

    // Result queue of one decision, the pending result and the output register.
    logic                r_q0_vld;
    logic                r_q1_vld;
    plms_pkg::t_seg_item r_q0;
    plms_pkg::t_seg_item r_q1;
    logic                r_pvld;
    plms_pkg::t_seg_item r_pend;
    logic                r_ovld;
    plms_pkg::t_seg_item r_out;

    logic                        in_acc;
    logic                        is_text;
    logic [AW-1:0]               wr_entry;
    logic                        entry_ok;
    logic                        st_we;
    logic                        ln_we;
    logic [AW-1:0]               ln_addr;
    logic [LW-1:0]               ln_val;
    logic [8*MAX_PHRASE_LEN-1:0] rd_row;
    logic [LW-1:0]               rd_len;
    logic [7:0]                  head;
    logic                        match;
    plms_pkg::t_win_ctl          win_ctl;
    logic [EW-1:0]               used;
    logic                        hit;
    logic [2:0]                  cls;
    logic                        single;
    logic                        close_need;
    logic [31:0]                 run_len;
    plms_pkg::t_seg_item         run_seg;
    plms_pkg::t_seg_item         dec_seg;
    plms_pkg::t_seg_item         fin_seg;
    logic                        can_push;
    logic                        push_req;
    plms_pkg::t_seg_item         push_item;
    logic                        push_ok;
    logic                        load_out;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_eiu};

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_text    = (i_in_data.cmd == plms_pkg::CMD_TEXT);
    assign wr_entry   = AW'(i_in_data.entry_index);
    assign entry_ok   = (32'(i_in_data.entry_index) < MAX_ENTRIES);

    assign st_we = in_acc && (i_in_data.cmd == plms_pkg::CMD_WR_BYTE) && entry_ok &&
                   (32'(i_in_data.char_offset) < MAX_PHRASE_LEN);

    // The clearing pass owns the length write port until it finishes.
    assign ln_we   = (r_state == S_CLEAR) ||
                     (in_acc && (i_in_data.cmd == plms_pkg::CMD_SET_LEN) && entry_ok);
    assign ln_addr = (r_state == S_CLEAR) ? r_e[AW-1:0] : wr_entry;
    assign ln_val  = (r_state == S_CLEAR) ? '0 : i_in_data.phrase_length;

    plms_dict #(
        .MAX_ENTRIES    (MAX_ENTRIES),
        .MAX_PHRASE_LEN (MAX_PHRASE_LEN)
    ) u_dict (
        .i_clk     (i_clk),
        .i_st_we   (st_we),
        .i_st_addr (wr_entry),
        .i_st_off  (OW'(i_in_data.char_offset)),
        .i_st_byte (i_in_data.byte_value),
        .i_ln_we   (ln_we),
        .i_ln_addr (ln_addr),
        .i_ln_val  (ln_val),
        .i_rd_addr (r_e[AW-1:0]),
        .o_row     (rd_row),
        .o_len     (rd_len)
    );

    assign win_ctl.load  = in_acc && is_text;
    assign win_ctl.shift = (r_state == S_SHIFT);
    assign win_ctl.data  = i_in_data.byte_value;

    plms_window #(
        .MAX_PHRASE_LEN (MAX_PHRASE_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_ctl   (win_ctl),
        .i_fill  (r_fill),
        .i_row   (rd_row),
        .i_len   (rd_len),
        .o_head  (head),
        .o_match (match)
    );

    // Entries beyond the dictionary size are treated as absent.
    assign used = (32'(r_eiu) > MAX_ENTRIES) ? EW'(MAX_ENTRIES) : EW'(r_eiu);

    // A row read last cycle wins only if it is strictly longer than the best so
    // far, which keeps the lowest entry on a tie.
    assign hit = r_cvld && (rd_len != '0) && (32'(rd_len) <= MAX_PHRASE_LEN) &&
                 (32'(rd_len) <= 32'(r_fill)) && (rd_len > r_best) && match;

    assign cls        = plms_pkg::byte_class(head);
    assign single     = (cls == plms_pkg::CL_PUNCT) || (cls == plms_pkg::CL_RAW);
    assign close_need = (r_rcls != plms_pkg::CL_NONE) &&
                        ((r_best != '0) || single || (r_rcls != cls));

    always_comb begin
        run_len = r_pos - r_rstart;
        if (run_len == 32'd0) begin
            run_len = 32'd1;
        end
        run_seg            = '0;
        run_seg.seg_kind   = plms_pkg::KIND_TOKEN;
        run_seg.seg_start  = r_rstart;
        run_seg.seg_length = run_len;
    end

    // The segment a decision emits at the head: a phrase or a single byte.
    always_comb begin
        dec_seg           = '0;
        dec_seg.seg_start = r_pos;
        if (r_best != '0) begin
            dec_seg.seg_kind   = plms_pkg::KIND_TOKEN;
            dec_seg.seg_length = 32'(r_best);
        end else begin
            dec_seg.seg_kind   = (cls == plms_pkg::CL_RAW) ?
                                 plms_pkg::KIND_RAW : plms_pkg::KIND_TOKEN;
            dec_seg.seg_length = 32'd1;
        end
    end

    // The pending result is the last one of this input beat.
    always_comb begin
        fin_seg           = r_pend;
        fin_seg.burst_end = 1'b1;
        fin_seg.text_end  = r_last;
    end

    assign can_push  = !r_ovld || i_out_ready;
    assign push_req  = ((r_state == S_PUSH0) && r_q0_vld) ||
                       ((r_state == S_PUSH1) && r_q1_vld);
    assign push_item = (r_state == S_PUSH0) ? r_q0 : r_q1;
    // A new result displaces the pending one into the output register.
    assign push_ok   = !r_pvld || can_push;
    assign load_out  = r_pvld && (((push_req && push_ok)) ||
                                  ((r_state == S_FIN) && can_push));

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_eiu     <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_rstart  <= '0;
            r_rcls    <= plms_pkg::CL_NONE;
            r_skip    <= '0;
            r_last    <= 1'b0;
            r_closing <= 1'b0;
            r_e       <= '0;
            r_cvld    <= 1'b0;
            r_best    <= '0;
            r_q0_vld  <= 1'b0;
            r_q1_vld  <= 1'b0;
            r_pvld    <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_eiu <= pwdata[7:0];
            end

            if (load_out) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state) inside
                S_CLEAR: begin
                    if (r_e == EW'(MAX_ENTRIES - 1)) begin
                        r_e     <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc && is_text) begin
                        r_fill  <= r_fill + 1'b1;
                        r_last  <= i_in_data.text_last;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_last) begin
                        r_state <= (r_fill != '0) ? S_DEC : S_CLOSE;
                    end else begin
                        r_state <= (r_fill == FW'(MAX_PHRASE_LEN)) ? S_DEC : S_FIN;
                    end
                end
                S_DEC: begin
                    r_q0_vld <= 1'b0;
                    r_q1_vld <= 1'b0;
                    if (r_skip != '0) begin
                        r_skip  <= r_skip - 1'b1;
                        r_state <= S_SHIFT;
                    end else begin
                        r_e     <= '0;
                        r_cvld  <= 1'b0;
                        r_best  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_e < used) begin
                        r_e    <= r_e + 1'b1;
                        r_cvld <= 1'b1;
                    end else begin
                        r_cvld <= 1'b0;
                    end
                    if (hit) begin
                        r_best <= rd_len;
                    end
                    if (!(r_e < used) && !r_cvld) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_q0_vld <= close_need;
                    r_q0     <= run_seg;
                    r_q1     <= dec_seg;
                    r_q1_vld <= (r_best != '0) || single;
                    if (r_best != '0) begin
                        r_skip <= r_best - 1'b1;
                        r_rcls <= plms_pkg::CL_NONE;
                    end else if (single) begin
                        r_rcls <= plms_pkg::CL_NONE;
                    end else begin
                        if (r_rcls != cls) begin
                            r_rcls   <= cls;
                            r_rstart <= r_pos;
                        end
                    end
                    r_state <= S_PUSH0;
                end
                S_PUSH0, S_PUSH1: begin
                    if (push_req && !push_ok) begin
                        r_state <= r_state;
                    end else begin
                        if (push_req) begin
                            if (r_pvld) begin
                                r_out <= r_pend;
                            end
                            r_pend <= push_item;
                            r_pvld <= 1'b1;
                        end
                        if (r_state == S_PUSH0) begin
                            r_state <= S_PUSH1;
                        end else begin
                            r_state <= r_closing ? S_FIN : S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    r_fill <= r_fill - 1'b1;
                    if (r_pos != 32'hffff_ffff) begin
                        r_pos <= r_pos + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_CLOSE: begin
                    r_q0_vld  <= (r_rcls != plms_pkg::CL_NONE);
                    r_q0      <= run_seg;
                    r_q1_vld  <= 1'b0;
                    r_rcls    <= plms_pkg::CL_NONE;
                    r_closing <= 1'b1;
                    r_state   <= S_PUSH0;
                end
                S_FIN: begin
                    if (!r_pvld || can_push) begin
                        if (r_pvld) begin
                            r_out  <= fin_seg;
                            r_pvld <= 1'b0;
                        end
                        if (r_last) begin
                            r_fill   <= '0;
                            r_pos    <= '0;
                            r_rstart <= '0;
                            r_rcls   <= plms_pkg::CL_NONE;
                            r_skip   <= '0;
                        end
                        r_closing <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
